// ===== rtl/fovpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fovpm_pkg: shared constants and types for the projection matrix block
// Field widths, fixed-point formats, register codes and the reciprocal table
// used by the series dividers.
// ----------------------------------------------------------------------------
package fovpm_pkg;

	// Port and field widths.
	localparam int ANGLE_W  = 16;
	localparam int DEPTH_W  = 32;
	localparam int RES_W    = 32;
	localparam int ERR_W    = 3;
	localparam int CIDX_W   = 1;

	// Default number of fraction bits in the results.
	localparam int RESULT_FRAC_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_NEAR = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_FAR  = 1'b1;

	// Reset values of the depth registers, unsigned Q16.16.
	localparam logic [DEPTH_W-1:0] NEAR_RESET = 32'd6554;
	localparam logic [DEPTH_W-1:0] FAR_RESET  = 32'd6553600;

	// Error bit positions.
	localparam int ERR_XSPAN = 0;
	localparam int ERR_YSPAN = 1;
	localparam int ERR_DEPTH = 2;

	// Series arithmetic: |a| in Q3.28, terms two through twenty-two.
	localparam int ANG_SHIFT   = 15;
	localparam int Q_FRAC      = 28;
	localparam int X_W         = 31;
	localparam int T_W         = 35;
	localparam int ACC_W       = 36;
	localparam int NUM_TERMS   = 21;
	localparam int RND_SHIFT   = 10;
	localparam int SC_W        = 22;
	localparam int RECIP_SHIFT = 35;

	// Products and spans of the sine and cosine pairs.
	localparam int PROD_W = 2 * SC_W;
	localparam int SPAN_W = PROD_W + 1;

	// Quotient bits kept by each divider, one of them a rounding bit.
	localparam int QUO_W = 33;

	// Depth offset divisor carries sixteen extra fraction bits.
	localparam int DEPTH_FRAC = 16;

	// floor(2^35 / k) for k = 2 .. 22.
	localparam logic [T_W-1:0] RECIP_TBL [0:NUM_TERMS-1] = '{
		35'd17179869184, 35'd11453246122, 35'd8589934592, 35'd6871947673,
		35'd5726623061,  35'd4908534052,  35'd4294967296, 35'd3817748707,
		35'd3435973836,  35'd3123612578,  35'd2863311530, 35'd2643056797,
		35'd2454267026,  35'd2290649224,  35'd2147483648, 35'd2021161080,
		35'd1908874353,  35'd1808407282,  35'd1717986918, 35'd1636178017,
		35'd1561806289
	};

	// Sign and error flags that travel beside the dividers.
	typedef struct packed {
		logic       neg_xs;
		logic       neg_ys;
		logic       neg_xo;
		logic       neg_yo;
		logic       neg_ds;
		logic       neg_do;
		logic [ERR_W-1:0] err;
	} side_t;

endpackage

// ===== rtl/fovpm_div.sv =====
// ----------------------------------------------------------------------------
// fovpm_div: pipelined restoring divider
// Forms floor(num * 2^(FB+1) / den) one quotient bit per stage, with an
// overflow flag when the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module fovpm_div #(
	parameter int NW = 45,
	parameter int DW = 45,
	parameter int QW = fovpm_pkg::QUO_W,
	parameter int FB = fovpm_pkg::RESULT_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int LW = QW - FB - 1;
	localparam int HW = NW - LW;
	localparam int CW = ((HW > DW) ? HW : DW) + 1;
	localparam int SW = FB + 1;

	logic [HW-1:0] hi;
	logic [QW-1:0] lo_init;
	logic          ovf_init;

	logic [DW-1:0] rem_s [0:QW-1];
	logic [DW-1:0] den_s [0:QW-1];
	logic [QW-1:0] lo_s  [0:QW-1];
	logic [QW-1:0] quo_s [0:QW];
	logic          ovf_s [0:QW];

	// The upper numerator bits must stay below the divisor for the quotient to fit.
	assign hi       = num[NW-1:LW];
	assign lo_init  = {num[LW-1:0], {SW{1'b0}}};
	assign ovf_init = CW'(hi) >= CW'(den);

	// Entry stage loads the partial remainder and the bits still to shift in.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(CW'(hi));
			den_s[0] <= den;
			lo_s[0]  <= lo_init;
			quo_s[0] <= '0;
			ovf_s[0] <= ovf_init;
		end
	end

	// One compare and subtract per stage.
	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[i-1], lo_s[i-1][QW-1]};
			diff  = trial - {1'b0, den_s[i-1]};
			ge    = trial >= {1'b0, den_s[i-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= {quo_s[i-1][QW-2:0], ge};
				ovf_s[i] <= ovf_s[i-1];
			end
		end

		if (i < QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
					den_s[i] <= den_s[i-1];
					lo_s[i]  <= {lo_s[i-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

// ===== rtl/fov_projection_matrix.sv =====
// ----------------------------------------------------------------------------
// fov_projection_matrix: asymmetric field-of-view projection matrix entries
// Takes four view angles per request and returns the six variable entries of
// the perspective projection matrix together with three error bits.
//
// Usage: a request on the input channel (in_valid, in_stall) carries the
// left, right, up and down angles in signed Q3.13 radians. Each request gives
// exactly one result on the output channel (out_valid, out_stall). The near
// and far depths are written through cfg_write, cfg_index and cfg_data while
// no request is in flight, a rule for the user that the block does not enforce.
// Throughput: one request per cycle while the output is not stalled. The
// pipeline holds 64 series stages (an entry stage and three per Taylor term),
// one rounding stage, two product and span stages, QUO_W + 1 divider stages
// and one output stage. The pipeline depth is set by the twenty-one term sine
// and cosine series and by the bit-per-stage restoring dividers.
// Reset clears every valid bit and loads the default depths.
// A stalled result holds the whole pipeline; in_stall is high exactly while
// a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module fov_projection_matrix #(
	parameter int RESULT_FRAC_BITS = fovpm_pkg::RESULT_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [fovpm_pkg::CIDX_W-1:0]         cfg_index,
	input  logic [fovpm_pkg::DEPTH_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [fovpm_pkg::ANGLE_W-1:0] left_angle,
	input  logic signed [fovpm_pkg::ANGLE_W-1:0] right_angle,
	input  logic signed [fovpm_pkg::ANGLE_W-1:0] up_angle,
	input  logic signed [fovpm_pkg::ANGLE_W-1:0] down_angle,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fovpm_pkg::RES_W-1:0]   x_scale,
	output logic signed [fovpm_pkg::RES_W-1:0]   y_scale,
	output logic signed [fovpm_pkg::RES_W-1:0]   x_offset,
	output logic signed [fovpm_pkg::RES_W-1:0]   y_offset,
	output logic signed [fovpm_pkg::RES_W-1:0]   depth_scale,
	output logic signed [fovpm_pkg::RES_W-1:0]   depth_offset,
	output logic [fovpm_pkg::ERR_W-1:0]          error_bits
);

	localparam int QW       = fovpm_pkg::QUO_W;
	localparam int LANE_STG = 1 + 3 * fovpm_pkg::NUM_TERMS;
	localparam int NSTG     = LANE_STG + 1 + 2 + (QW + 1) + 1;
	localparam int AW       = fovpm_pkg::ANGLE_W;
	localparam int XW       = fovpm_pkg::X_W;
	localparam int TW       = fovpm_pkg::T_W;
	localparam int ACW      = fovpm_pkg::ACC_W;
	localparam int SCW      = fovpm_pkg::SC_W;
	localparam int PW       = fovpm_pkg::PROD_W;
	localparam int SPW      = fovpm_pkg::SPAN_W;
	localparam int DPW      = fovpm_pkg::DEPTH_W;
	localparam int RW       = fovpm_pkg::RES_W;
	localparam logic [RW-1:0] SAT_POS = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0] SAT_NEG = {1'b1, {(RW-1){1'b0}}};

	// Round a Q28 sum to Q18, ties away from zero, optionally negated.
	function automatic logic signed [SCW-1:0] rnd_q18(input logic signed [ACW-1:0] v,
			input logic flip);
		logic [ACW-1:0] mag;
		logic [ACW-1:0] r;
		mag = v[ACW-1] ? ACW'(-v) : ACW'(v);
		r = (mag + ACW'(512)) >> fovpm_pkg::RND_SHIFT;
		rnd_q18 = (v[ACW-1] ^ flip) ? -SCW'(r) : SCW'(r);
	endfunction

	// Magnitude of a signed span or numerator.
	function automatic logic [SPW-1:0] mag_of(input logic signed [SPW-1:0] v);
		mag_of = v[SPW-1] ? SPW'(-v) : SPW'(v);
	endfunction

	// Round the extra quotient bit and saturate to the signed result range, or give zero on error.
	function automatic logic [RW-1:0] sat_res(input logic neg, input logic ovf,
			input logic zero, input logic [QW-1:0] qp);
		logic [QW-1:0] mag;
		mag = {1'b0, qp[QW-1:1]} + QW'(qp[0]);
		if (zero)
			sat_res = '0;
		else if (!neg)
			sat_res = (ovf || mag > QW'(SAT_POS)) ? SAT_POS : mag[RW-1:0];
		else
			sat_res = (ovf || mag >= QW'(SAT_NEG)) ? SAT_NEG : -mag[RW-1:0];
	endfunction

	logic                 adv;
	logic [NSTG-1:0]      vld_q;
	logic [DPW-1:0]       near_q;
	logic [DPW-1:0]       far_q;
	logic [AW-1:0]        ang_in [0:3];

	logic signed [SCW-1:0] sn_s65 [0:3];
	logic signed [SCW-1:0] cs_s65 [0:3];

	logic signed [PW-1:0]  prl_s66, plr_s66, pcx_s66;
	logic signed [PW-1:0]  pud_s66, pdu_s66, pcy_s66;
	logic [2*DPW-1:0]      fn_s66;

	logic [SPW-1:0]        xs_num_s67, xo_num_s67, dx_mag_s67;
	logic [SPW-1:0]        ys_num_s67, yo_num_s67, dy_mag_s67;
	logic [DPW-1:0]        far_s67, span_s67;
	logic [2*DPW-1:0]      fn_s67;
	fovpm_pkg::side_t      side_s67;

	fovpm_pkg::side_t      side_d [0:QW];

	logic [QW-1:0]         q_xs, q_xo, q_ys, q_yo, q_ds, q_do;
	logic                  o_xs, o_xo, o_ys, o_yo, o_ds, o_do;

	logic [RW-1:0]         xs_sf, ys_sf, xo_sf, yo_sf, ds_sf, do_sf;
	logic [fovpm_pkg::ERR_W-1:0] err_sf;

	// The whole pipeline moves unless a finished result is held by the receiver.
	assign adv      = !(vld_q[NSTG-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[NSTG-1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	// Depth registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= fovpm_pkg::NEAR_RESET;
			far_q  <= fovpm_pkg::FAR_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				fovpm_pkg::CFG_NEAR: near_q <= cfg_data;
				fovpm_pkg::CFG_FAR:  far_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lane order: left, right, up, down.
	always_comb begin
		ang_in[0] = left_angle;
		ang_in[1] = right_angle;
		ang_in[2] = up_angle;
		ang_in[3] = down_angle;
	end

	// Sine and cosine series, three stages per term in each lane.
	for (genvar ln = 0; ln < 4; ln++) begin : g_lane
		logic [XW-1:0]         x_s  [0:LANE_STG-2];
		logic                  neg_s [0:LANE_STG-1];
		logic signed [ACW-1:0] sa_s [0:LANE_STG-1];
		logic signed [ACW-1:0] ca_s [0:LANE_STG-1];
		logic [TW-1:0]         t_s  [0:fovpm_pkg::NUM_TERMS-1];
		logic [TW-1:0]         p_s  [0:fovpm_pkg::NUM_TERMS-1];
		logic [TW-1:0]         pb_s [0:fovpm_pkg::NUM_TERMS-1];
		logic [TW-1:0]         q0_s [0:fovpm_pkg::NUM_TERMS-1];
		logic [AW-1:0]         amag;

		// Entry: magnitude of the angle moved to Q3.28.
		assign amag = ang_in[ln][AW-1] ? AW'((AW+1)'(1) << AW) - ang_in[ln] : ang_in[ln];

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[0]   <= {amag, {fovpm_pkg::ANG_SHIFT{1'b0}}};
				neg_s[0] <= ang_in[ln][AW-1];
				t_s[0]   <= TW'({amag, {fovpm_pkg::ANG_SHIFT{1'b0}}});
				sa_s[0]  <= signed'(ACW'({amag, {fovpm_pkg::ANG_SHIFT{1'b0}}}));
				ca_s[0]  <= signed'(ACW'(1) << fovpm_pkg::Q_FRAC);
			end
		end

		for (genvar j = 0; j < fovpm_pkg::NUM_TERMS; j++) begin : g_term
			localparam int  K     = j + 2;
			localparam int  GA    = 1 + 3 * j;
			localparam bit  ODD   = (K % 2) == 1;
			localparam bit  MINUS = ODD ? (((K - 1) / 2) % 2 == 1) : ((K / 2) % 2 == 1);

			logic [TW+XW-1:0]      prod_a;
			logic [2*TW-1:0]       prod_b;
			logic [TW-1:0]         rem_c;
			logic [TW-1:0]         qc;
			logic signed [ACW-1:0] term_c;

			// Previous term times |a|.
			assign prod_a = (TW+XW)'(t_s[j]) * (TW+XW)'(x_s[GA-1]);

			always_ff @(posedge clk) begin
				if (adv) begin
					p_s[j]      <= prod_a[fovpm_pkg::Q_FRAC +: TW];
					x_s[GA]     <= x_s[GA-1];
					neg_s[GA]   <= neg_s[GA-1];
					sa_s[GA]    <= sa_s[GA-1];
					ca_s[GA]    <= ca_s[GA-1];
				end
			end

			// Estimate of the quotient by the term index through its reciprocal.
			assign prod_b = (2*TW)'(p_s[j]) * (2*TW)'(fovpm_pkg::RECIP_TBL[j]);

			always_ff @(posedge clk) begin
				if (adv) begin
					q0_s[j]     <= prod_b[fovpm_pkg::RECIP_SHIFT +: TW];
					pb_s[j]     <= p_s[j];
					x_s[GA+1]   <= x_s[GA];
					neg_s[GA+1] <= neg_s[GA];
					sa_s[GA+1]  <= sa_s[GA];
					ca_s[GA+1]  <= ca_s[GA];
				end
			end

			// The estimate is at most one short; correct it and accumulate.
			always_comb begin
				rem_c  = pb_s[j] - TW'(q0_s[j] * TW'(K));
				qc     = (rem_c >= TW'(K)) ? q0_s[j] + TW'(1) : q0_s[j];
				term_c = signed'(ACW'(qc));
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					neg_s[GA+2] <= neg_s[GA+1];
					if (ODD) begin
						sa_s[GA+2] <= MINUS ? sa_s[GA+1] - term_c : sa_s[GA+1] + term_c;
						ca_s[GA+2] <= ca_s[GA+1];
					end else begin
						sa_s[GA+2] <= sa_s[GA+1];
						ca_s[GA+2] <= MINUS ? ca_s[GA+1] - term_c : ca_s[GA+1] + term_c;
					end
				end
			end

			if (j < fovpm_pkg::NUM_TERMS - 1) begin : g_next
				always_ff @(posedge clk) begin
					if (adv) begin
						t_s[j+1]    <= qc;
						x_s[GA+2]   <= x_s[GA+1];
					end
				end
			end
		end

		// Rounding to Q4.18; the sine takes the sign of the angle.
		always_ff @(posedge clk) begin
			if (adv) begin
				sn_s65[ln] <= rnd_q18(sa_s[LANE_STG-1], neg_s[LANE_STG-1]);
				cs_s65[ln] <= rnd_q18(ca_s[LANE_STG-1], 1'b0);
			end
		end
	end

	// Cross products of the sine and cosine pairs and the depth product.
	always_ff @(posedge clk) begin
		if (adv) begin
			prl_s66 <= PW'(sn_s65[1]) * PW'(cs_s65[0]);
			plr_s66 <= PW'(sn_s65[0]) * PW'(cs_s65[1]);
			pcx_s66 <= PW'(cs_s65[1]) * PW'(cs_s65[0]);
			pud_s66 <= PW'(sn_s65[2]) * PW'(cs_s65[3]);
			pdu_s66 <= PW'(sn_s65[3]) * PW'(cs_s65[2]);
			pcy_s66 <= PW'(cs_s65[2]) * PW'(cs_s65[3]);
			fn_s66  <= (2*DPW)'(far_q) * (2*DPW)'(near_q);
		end
	end

	// Spans, numerators, signs and error flags.
	logic signed [SPW-1:0] dx_c, dy_c, nxs_c, nxo_c, nys_c, nyo_c;
	logic                  dneg_c;
	logic [DPW-1:0]        span_c;

	always_comb begin
		dx_c   = SPW'(prl_s66) - SPW'(plr_s66);
		dy_c   = SPW'(pud_s66) - SPW'(pdu_s66);
		nxs_c  = SPW'(pcx_s66) <<< 1;
		nys_c  = SPW'(pcy_s66) <<< 1;
		nxo_c  = SPW'(prl_s66) + SPW'(plr_s66);
		nyo_c  = SPW'(pud_s66) + SPW'(pdu_s66);
		dneg_c = near_q < far_q;
		span_c = dneg_c ? far_q - near_q : near_q - far_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_num_s67 <= mag_of(nxs_c);
			xo_num_s67 <= mag_of(nxo_c);
			dx_mag_s67 <= mag_of(dx_c);
			ys_num_s67 <= mag_of(nys_c);
			yo_num_s67 <= mag_of(nyo_c);
			dy_mag_s67 <= mag_of(dy_c);
			far_s67    <= far_q;
			fn_s67     <= fn_s66;
			span_s67   <= span_c;
			side_s67.neg_xs <= nxs_c[SPW-1] ^ dx_c[SPW-1];
			side_s67.neg_xo <= nxo_c[SPW-1] ^ dx_c[SPW-1];
			side_s67.neg_ys <= nys_c[SPW-1] ^ dy_c[SPW-1];
			side_s67.neg_yo <= nyo_c[SPW-1] ^ dy_c[SPW-1];
			side_s67.neg_ds <= dneg_c;
			side_s67.neg_do <= dneg_c;
			side_s67.err[fovpm_pkg::ERR_XSPAN] <= dx_c == '0;
			side_s67.err[fovpm_pkg::ERR_YSPAN] <= dy_c == '0;
			side_s67.err[fovpm_pkg::ERR_DEPTH] <= near_q == far_q;
		end
	end

	// Flags follow the dividers stage by stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s67;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// Six dividers, one per variable matrix entry.
	fovpm_div #(.NW(SPW), .DW(SPW), .QW(QW), .FB(RESULT_FRAC_BITS)) u_div_xs (
		.clk(clk), .en(adv), .num(xs_num_s67), .den(dx_mag_s67), .quo(q_xs), .ovf(o_xs)
	);
	fovpm_div #(.NW(SPW), .DW(SPW), .QW(QW), .FB(RESULT_FRAC_BITS)) u_div_xo (
		.clk(clk), .en(adv), .num(xo_num_s67), .den(dx_mag_s67), .quo(q_xo), .ovf(o_xo)
	);
	fovpm_div #(.NW(SPW), .DW(SPW), .QW(QW), .FB(RESULT_FRAC_BITS)) u_div_ys (
		.clk(clk), .en(adv), .num(ys_num_s67), .den(dy_mag_s67), .quo(q_ys), .ovf(o_ys)
	);
	fovpm_div #(.NW(SPW), .DW(SPW), .QW(QW), .FB(RESULT_FRAC_BITS)) u_div_yo (
		.clk(clk), .en(adv), .num(yo_num_s67), .den(dy_mag_s67), .quo(q_yo), .ovf(o_yo)
	);
	fovpm_div #(.NW(DPW), .DW(DPW), .QW(QW), .FB(RESULT_FRAC_BITS)) u_div_ds (
		.clk(clk), .en(adv), .num(far_s67), .den(span_s67), .quo(q_ds), .ovf(o_ds)
	);
	fovpm_div #(.NW(2*DPW), .DW(DPW+fovpm_pkg::DEPTH_FRAC), .QW(QW),
			.FB(RESULT_FRAC_BITS)) u_div_do (
		.clk(clk), .en(adv), .num(fn_s67),
		.den({span_s67, {fovpm_pkg::DEPTH_FRAC{1'b0}}}), .quo(q_do), .ovf(o_do)
	);

	// Output stage: rounding, saturation and zeroing on error.
	always_ff @(posedge clk) begin
		if (adv) begin
			xs_sf  <= sat_res(side_d[QW].neg_xs, o_xs,
				side_d[QW].err[fovpm_pkg::ERR_XSPAN], q_xs);
			xo_sf  <= sat_res(side_d[QW].neg_xo, o_xo,
				side_d[QW].err[fovpm_pkg::ERR_XSPAN], q_xo);
			ys_sf  <= sat_res(side_d[QW].neg_ys, o_ys,
				side_d[QW].err[fovpm_pkg::ERR_YSPAN], q_ys);
			yo_sf  <= sat_res(side_d[QW].neg_yo, o_yo,
				side_d[QW].err[fovpm_pkg::ERR_YSPAN], q_yo);
			ds_sf  <= sat_res(side_d[QW].neg_ds, o_ds,
				side_d[QW].err[fovpm_pkg::ERR_DEPTH], q_ds);
			do_sf  <= sat_res(side_d[QW].neg_do, o_do,
				side_d[QW].err[fovpm_pkg::ERR_DEPTH], q_do);
			err_sf <= side_d[QW].err;
		end
	end

	assign x_scale      = xs_sf;
	assign x_offset     = xo_sf;
	assign y_scale      = ys_sf;
	assign y_offset     = yo_sf;
	assign depth_scale  = ds_sf;
	assign depth_offset = do_sf;
	assign error_bits   = err_sf;

`ifndef SYNTHESIS
	a_xspan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_bits[fovpm_pkg::ERR_XSPAN] |-> x_scale == '0 && x_offset == '0)
		else $error("x entries not cleared on zero horizontal span");
	a_yspan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_bits[fovpm_pkg::ERR_YSPAN] |-> y_scale == '0 && y_offset == '0)
		else $error("y entries not cleared on zero vertical span");
	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_bits[fovpm_pkg::ERR_DEPTH] |->
		depth_scale == '0 && depth_offset == '0)
		else $error("depth entries not cleared on equal depths");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_q))
		else $error("pipeline moved while the result was stalled");
`endif

endmodule
